// ===== rtl/mipi_pkg.sv =====
// Package for the motor inductance pulse identifier: phase, fault and
// sequencer codes, register indexes, default parameters and port widths.
// Used by the top module; depends on nothing.
package mipi_pkg;

  localparam int CURRENT_BITS_DEF = 16;
  localparam int TICK_BITS_DEF    = 16;

  // Result item: 234 bits of fields, padded to whole bytes.
  localparam int OUT_DATA_W = 240;
  localparam int IN_USER_W  = 2;
  localparam int PADDR_W    = 5;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_REST  = 3'd1,
    PH_PULSE = 3'd2,
    PH_DONE  = 3'd3,
    PH_FAULT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_BAD_CFG   = 2'd1,
    FLT_OVERCUR   = 2'd2,
    FLT_NO_SAMPLE = 2'd3
  } fault_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_DROP,
    SQ_EFF,
    SQ_LMUL,
    SQ_LDIV,
    SQ_NEXT,
    SQ_FDIV_D,
    SQ_FDIV_Q,
    SQ_FDIV_S,
    SQ_FWB,
    SQ_PUSH
  } seq_t;

  localparam logic [2:0] REG_TEST_VOLTAGE   = 3'd0;
  localparam logic [2:0] REG_PULSE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_REST_LENGTH    = 3'd2;
  localparam logic [2:0] REG_PAIRS_PER_AXIS = 3'd3;
  localparam logic [2:0] REG_PULSE_GAIN     = 3'd4;
  localparam logic [2:0] REG_MIN_DELTA      = 3'd5;
  localparam logic [2:0] REG_PHASE_RES      = 3'd6;
  localparam logic [2:0] REG_CURRENT_LIMIT  = 3'd7;

endpackage

// ===== rtl/mipi_serial_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Unsigned operands; product valid with the done pulse. Uses no package items.
module mipi_serial_mul #(
  parameter int A_W = 32,
  parameter int B_W = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] prod;
  logic [A_W+B_W-1:0] prod_next;
  logic [A_W:0]       part;
  logic [CW-1:0]      cnt;
  logic               busy;

  always_comb begin
    part      = {1'b0, prod[A_W+B_W-1:B_W]} + (prod[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});
    prod_next = {part, prod[B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(B_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      prod <= {{A_W{1'b0}}, b};
    end else if (busy) begin
      prod <= prod_next;
    end
  end

  assign product = prod;

endmodule

// ===== rtl/mipi_serial_div.sv =====
// Restoring radix-2 divider: one quotient bit per cycle.
// Unsigned; divisor must be nonzero. Uses no package items.
module mipi_serial_div #(
  parameter int D_W = 51,
  parameter int V_W = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D_W-1:0] dividend,
  input  logic [V_W-1:0] divisor,
  output logic           done,
  output logic [D_W-1:0] quotient
);

  localparam int CW = $clog2(D_W + 1);

  logic [V_W-1:0] div_r;
  logic [V_W-1:0] rem;
  logic [D_W-1:0] quo;
  logic [V_W:0]   r_sh;
  logic [V_W:0]   r_sub;
  logic           ge;
  logic [CW-1:0]  cnt;
  logic           busy;

  always_comb begin
    r_sh  = {rem, quo[D_W-1]};
    r_sub = r_sh - {1'b0, div_r};
    ge    = (r_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(D_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem   <= '0;
      quo   <= dividend;
    end else if (busy) begin
      rem <= ge ? r_sub[V_W-1:0] : r_sh[V_W-1:0];
      quo <= {quo[D_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/motor_inductance_pulse_identifier.sv =====
// Inductance identifier top: APB registers, run sequencer and sample datapath;
// depends on mipi_pkg, mipi_serial_mul and mipi_serial_div.
// One transaction at a time: a plain tick passes EVAL and PUSH, which shows
// m_tvalid and reopens the input; PUSH waits while an unaccepted result is held.
// A pulse end adds up to two serial multiplies and a divide, and a run end up to
// three more divides. Sync reset clears run and results; regs default.
module motor_inductance_pulse_identifier #(
  parameter int CURRENT_BITS = mipi_pkg::CURRENT_BITS_DEF,
  parameter int TICK_BITS    = mipi_pkg::TICK_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [CB-1:0] id_current, [2CB-1:CB] iq_current, rest zero
  input  logic [((2*CURRENT_BITS+7)/8)*8-1:0] s_tdata,
  // [0] opcode, [1] dual_axis
  input  logic [mipi_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [16:0] vd_reference, [33:17] vq_reference, [36:34] phase_code,
  // [38:37] fault_code, [39] axis_now, [71:40] d_inductance,
  // [103:72] q_inductance, [135:104] mean_inductance,
  // [168:136] saliency_difference, [184:169] mean_current_step,
  // [201:185] last_current_step, [233:202] last_sample_value, rest zero
  output logic [mipi_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mipi_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CB   = CURRENT_BITS;
  localparam int TB   = TICK_BITS;
  localparam int AW   = CB + 1;
  localparam int EW   = ((CB + 2 > 17) ? CB + 2 : 17) + 1;
  localparam int PW   = 32 + EW;
  localparam int XW   = CB + 18;
  localparam int KW   = (AW > 15) ? AW : 15;
  localparam int TW   = (TB > 16) ? TB : 16;
  localparam int DW   = PW;
  localparam int VW   = AW;
  localparam int SSW  = CB + 11;
  localparam int PADW = mipi_pkg::OUT_DATA_W - 234;

  // configuration registers
  logic [15:0] test_voltage, pulse_length, rest_length, winding_res;
  logic [7:0]  pairs_per_axis;
  logic [31:0] pulse_gain;
  logic [14:0] min_step, current_limit;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_voltage   <= 16'd0;
      pulse_length   <= 16'd1;
      rest_length    <= 16'd0;
      pairs_per_axis <= 8'd1;
      pulse_gain     <= 32'd0;
      min_step       <= 15'd0;
      winding_res    <= 16'd0;
      current_limit  <= 15'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mipi_pkg::REG_TEST_VOLTAGE:   test_voltage   <= pwdata[15:0];
        mipi_pkg::REG_PULSE_LENGTH:   pulse_length   <= pwdata[15:0];
        mipi_pkg::REG_REST_LENGTH:    rest_length    <= pwdata[15:0];
        mipi_pkg::REG_PAIRS_PER_AXIS: pairs_per_axis <= pwdata[7:0];
        mipi_pkg::REG_PULSE_GAIN:     pulse_gain     <= pwdata;
        mipi_pkg::REG_MIN_DELTA:      min_step       <= pwdata[14:0];
        mipi_pkg::REG_PHASE_RES:      winding_res    <= pwdata[15:0];
        mipi_pkg::REG_CURRENT_LIMIT:  current_limit  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mipi_pkg::REG_TEST_VOLTAGE:   prdata = {16'd0, test_voltage};
      mipi_pkg::REG_PULSE_LENGTH:   prdata = {16'd0, pulse_length};
      mipi_pkg::REG_REST_LENGTH:    prdata = {16'd0, rest_length};
      mipi_pkg::REG_PAIRS_PER_AXIS: prdata = {24'd0, pairs_per_axis};
      mipi_pkg::REG_PULSE_GAIN:     prdata = pulse_gain;
      mipi_pkg::REG_MIN_DELTA:      prdata = {17'd0, min_step};
      mipi_pkg::REG_PHASE_RES:      prdata = {16'd0, winding_res};
      mipi_pkg::REG_CURRENT_LIMIT:  prdata = {17'd0, current_limit};
      default:                      prdata = 32'd0;
    endcase
  end

  // sequencer and run state
  mipi_pkg::seq_t   seq, seq_next;
  mipi_pkg::phase_t phase;
  mipi_pkg::fault_t fault;
  logic             axis, neg, dual;
  logic [TB-1:0]    tick_count, tick_next;
  logic [7:0]       pair_idx, pc_inc;
  logic signed [CB-1:0] pulse_base;
  logic [40:0]      sum_d, sum_q;
  logic [8:0]       count_d, count_q;
  logic [SSW-1:0]   step_sum;
  logic [9:0]       step_count;
  logic [31:0]      ld, lq, lmean, lastsample;
  logic signed [32:0] diff;
  logic [15:0]      stepmean;
  logic signed [16:0] laststep;

  // latched item and sample registers
  logic             op_r, dual_in_r;
  logic signed [CB-1:0] id_r, iq_r;
  logic signed [AW-1:0] d_r;
  logic [AW-1:0]    absd_r;
  logic             se_neg_r;
  logic signed [EW-1:0] drop_r;

  // combinational sample path
  logic             accept, bad_cfg, active, overcur;
  logic             rest_end, pulse_end, pre_reject, eff_reject, q_reject;
  logic             more_pairs, to_q, no_sample;
  logic signed [CB-1:0] cur;
  logic [AW-1:0]    id_ext, iq_ext, abs_id, abs_iq, absd_w, abs_se;
  logic signed [AW-1:0] d_w, se_w;
  logic signed [XW-1:0] x_w, xr_w;
  logic signed [EW-1:0] drop_w, v_w, eff_w;
  logic [EW-1:0]    abse_w;
  logic signed [16:0] v_out;

  // shared serial units
  logic             mul_start, mul_done, div_start, div_done;
  logic [31:0]      mul_a;
  logic [EW-1:0]    mul_b;
  logic [PW-1:0]    mul_prod;
  logic [DW-1:0]    div_num, div_quo;
  logic [VW-1:0]    div_den;

  assign s_tready = (seq == mipi_pkg::SQ_IDLE);
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    bad_cfg = (test_voltage == 16'd0) || (pulse_length == 16'd0) ||
              (pairs_per_axis == 8'd0) || (pulse_gain == 32'd0);
    active  = (phase == mipi_pkg::PH_REST) || (phase == mipi_pkg::PH_PULSE);
    id_ext  = AW'(id_r);
    iq_ext  = AW'(iq_r);
    abs_id  = id_ext[AW-1] ? (~id_ext + 1'b1) : id_ext;
    abs_iq  = iq_ext[AW-1] ? (~iq_ext + 1'b1) : iq_ext;
    overcur = (current_limit != 15'd0) &&
              ((KW'(abs_id) > KW'(current_limit)) || (KW'(abs_iq) > KW'(current_limit)));
    tick_next = tick_count + TB'(1);
    rest_end  = TW'(tick_next) >= TW'(rest_length);
    pulse_end = TW'(tick_next) >= TW'(pulse_length);
    cur     = axis ? iq_r : id_r;
    d_w     = AW'(cur) - AW'(pulse_base);
    se_w    = AW'(cur) + AW'(pulse_base);
    absd_w  = d_w[AW-1] ? (~d_w + 1'b1) : d_w;
    abs_se  = se_w[AW-1] ? (~se_w + 1'b1) : se_w;
    pre_reject = (d_w == '0) || (KW'(absd_w) < KW'(min_step));
    // resistive drop, floor((R*(Is+Ie) + 2^16) / 2^17)
    x_w    = se_neg_r ? -$signed(mul_prod[XW-1:0]) : $signed(mul_prod[XW-1:0]);
    xr_w   = x_w + XW'(32'sd65536);
    drop_w = EW'(xr_w >>> 17);
    v_w    = neg ? -EW'($signed({1'b0, test_voltage})) : EW'($signed({1'b0, test_voltage}));
    eff_w  = v_w - drop_r;
    abse_w = eff_w[EW-1] ? (~eff_w + 1'b1) : eff_w;
    eff_reject = (eff_w == '0) || (eff_w[EW-1] != d_r[AW-1]);
    q_reject   = (div_quo[DW-1:32] != '0) || (div_quo[31:0] == 32'd0);
    pc_inc     = pair_idx + 8'd1;
    more_pairs = pc_inc < pairs_per_axis;
    to_q       = !axis && dual;
    no_sample  = (count_d == 9'd0) || (dual && (count_q == 9'd0));
    v_out      = neg ? -17'($signed({1'b0, test_voltage})) : 17'($signed({1'b0, test_voltage}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= mipi_pkg::SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next  = seq;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = pulse_gain;
    mul_b     = abse_w;
    div_num   = mul_prod;
    div_den   = absd_r;
    case (seq)
      mipi_pkg::SQ_IDLE: begin
        if (accept) seq_next = mipi_pkg::SQ_EVAL;
      end
      mipi_pkg::SQ_EVAL: begin
        mul_a = {16'd0, winding_res};
        mul_b = EW'(abs_se);
        if (!op_r && active && !overcur && (phase == mipi_pkg::PH_PULSE) && pulse_end) begin
          if (pre_reject) begin
            seq_next = mipi_pkg::SQ_NEXT;
          end else begin
            mul_start = 1'b1;
            seq_next  = mipi_pkg::SQ_DROP;
          end
        end else begin
          seq_next = mipi_pkg::SQ_PUSH;
        end
      end
      mipi_pkg::SQ_DROP: begin
        if (mul_done) seq_next = mipi_pkg::SQ_EFF;
      end
      mipi_pkg::SQ_EFF: begin
        if (eff_reject) begin
          seq_next = mipi_pkg::SQ_NEXT;
        end else begin
          mul_start = 1'b1;
          seq_next  = mipi_pkg::SQ_LMUL;
        end
      end
      mipi_pkg::SQ_LMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          seq_next  = mipi_pkg::SQ_LDIV;
        end
      end
      mipi_pkg::SQ_LDIV: begin
        if (div_done) seq_next = mipi_pkg::SQ_NEXT;
      end
      mipi_pkg::SQ_NEXT: begin
        div_num = DW'(sum_d) + DW'(count_d >> 1);
        div_den = VW'(count_d);
        if (!neg || more_pairs || to_q || no_sample) begin
          seq_next = mipi_pkg::SQ_PUSH;
        end else begin
          div_start = 1'b1;
          seq_next  = mipi_pkg::SQ_FDIV_D;
        end
      end
      mipi_pkg::SQ_FDIV_D: begin
        if (dual) begin
          div_num = DW'(sum_q) + DW'(count_q >> 1);
          div_den = VW'(count_q);
        end else begin
          div_num = DW'(step_sum) + DW'(step_count >> 1);
          div_den = VW'(step_count);
        end
        if (div_done) begin
          if (dual) begin
            div_start = 1'b1;
            seq_next  = mipi_pkg::SQ_FDIV_Q;
          end else if (step_count != 10'd0) begin
            div_start = 1'b1;
            seq_next  = mipi_pkg::SQ_FDIV_S;
          end else begin
            seq_next = mipi_pkg::SQ_FWB;
          end
        end
      end
      mipi_pkg::SQ_FDIV_Q: begin
        div_num = DW'(step_sum) + DW'(step_count >> 1);
        div_den = VW'(step_count);
        if (div_done) begin
          if (step_count != 10'd0) begin
            div_start = 1'b1;
            seq_next  = mipi_pkg::SQ_FDIV_S;
          end else begin
            seq_next = mipi_pkg::SQ_FWB;
          end
        end
      end
      mipi_pkg::SQ_FDIV_S: begin
        if (div_done) seq_next = mipi_pkg::SQ_FWB;
      end
      mipi_pkg::SQ_FWB: begin
        seq_next = mipi_pkg::SQ_PUSH;
      end
      mipi_pkg::SQ_PUSH: begin
        if (!m_tvalid || m_tready) seq_next = mipi_pkg::SQ_IDLE;
      end
      default: seq_next = mipi_pkg::SQ_IDLE;
    endcase
  end

  mipi_serial_mul #(.A_W(32), .B_W(EW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  mipi_serial_div #(.D_W(DW), .V_W(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // latched item and sample operands
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= s_tuser[0];
      dual_in_r <= s_tuser[1];
      id_r      <= $signed(s_tdata[CB-1:0]);
      iq_r      <= $signed(s_tdata[2*CB-1:CB]);
    end
    if (seq == mipi_pkg::SQ_EVAL) begin
      d_r      <= d_w;
      absd_r   <= absd_w;
      se_neg_r <= se_w[AW-1];
    end
    if ((seq == mipi_pkg::SQ_DROP) && mul_done) drop_r <= drop_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mipi_pkg::PH_IDLE;
      fault <= mipi_pkg::FLT_NONE;
      axis <= 1'b0; neg <= 1'b0; dual <= 1'b0;
      tick_count <= '0; pair_idx <= 8'd0; pulse_base <= '0;
      sum_d <= '0; sum_q <= '0; count_d <= '0; count_q <= '0;
      step_sum <= '0; step_count <= '0;
      ld <= '0; lq <= '0; lmean <= '0; diff <= '0;
      stepmean <= '0; laststep <= '0; lastsample <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready && (seq != mipi_pkg::SQ_PUSH)) m_tvalid <= 1'b0;
      case (seq)
        mipi_pkg::SQ_EVAL: begin
          if (op_r) begin
            // start: clear the run and check configuration
            axis <= 1'b0; neg <= 1'b0; dual <= dual_in_r;
            tick_count <= '0; pair_idx <= 8'd0; pulse_base <= '0;
            sum_d <= '0; sum_q <= '0; count_d <= '0; count_q <= '0;
            step_sum <= '0; step_count <= '0;
            ld <= '0; lq <= '0; lmean <= '0; diff <= '0;
            stepmean <= '0; laststep <= '0; lastsample <= '0;
            if (bad_cfg) begin
              fault <= mipi_pkg::FLT_BAD_CFG;
              phase <= mipi_pkg::PH_FAULT;
            end else begin
              fault <= mipi_pkg::FLT_NONE;
              phase <= mipi_pkg::PH_REST;
            end
          end else if (active) begin
            if (overcur) begin
              fault <= mipi_pkg::FLT_OVERCUR;
              phase <= mipi_pkg::PH_FAULT;
            end else if (phase == mipi_pkg::PH_REST) begin
              if (rest_end) begin
                tick_count <= '0;
                pulse_base <= cur;
                phase      <= mipi_pkg::PH_PULSE;
              end else begin
                tick_count <= tick_next;
              end
            end else begin
              tick_count <= tick_next;
              if (pulse_end) laststep <= 17'(d_w);
            end
          end
        end
        mipi_pkg::SQ_LDIV: begin
          if (div_done && !q_reject) begin
            lastsample <= div_quo[31:0];
            if (!axis) begin
              sum_d   <= sum_d + 41'(div_quo[31:0]);
              count_d <= count_d + 9'd1;
            end else begin
              sum_q   <= sum_q + 41'(div_quo[31:0]);
              count_q <= count_q + 9'd1;
            end
            step_sum   <= step_sum + SSW'(absd_r);
            step_count <= step_count + 10'd1;
          end
        end
        mipi_pkg::SQ_NEXT: begin
          tick_count <= '0;
          if (!neg) begin
            neg   <= 1'b1;
            phase <= mipi_pkg::PH_REST;
          end else begin
            neg      <= 1'b0;
            pair_idx <= pc_inc;
            if (more_pairs) begin
              phase <= mipi_pkg::PH_REST;
            end else if (to_q) begin
              axis     <= 1'b1;
              pair_idx <= 8'd0;
              phase    <= mipi_pkg::PH_REST;
            end else if (no_sample) begin
              fault <= mipi_pkg::FLT_NO_SAMPLE;
              phase <= mipi_pkg::PH_FAULT;
            end
          end
        end
        mipi_pkg::SQ_FDIV_D: begin
          if (div_done) ld <= div_quo[31:0];
        end
        mipi_pkg::SQ_FDIV_Q: begin
          if (div_done) lq <= div_quo[31:0];
        end
        mipi_pkg::SQ_FDIV_S: begin
          if (div_done) begin
            stepmean <= (div_quo[DW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
          end
        end
        mipi_pkg::SQ_FWB: begin
          if (dual) begin
            lmean <= 32'(({1'b0, ld} + {1'b0, lq}) >> 1);
            diff  <= $signed({1'b0, lq}) - $signed({1'b0, ld});
          end else begin
            lq    <= ld;
            lmean <= ld;
            diff  <= '0;
          end
          phase <= mipi_pkg::PH_DONE;
        end
        mipi_pkg::SQ_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PADW{1'b0}}, lastsample, laststep, stepmean, diff, lmean, lq, ld,
                         axis, fault, phase,
                         ((phase == mipi_pkg::PH_PULSE) && axis)  ? v_out : 17'sd0,
                         ((phase == mipi_pkg::PH_PULSE) && !axis) ? v_out : 17'sd0};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
